// File: rtl/core/pbsb_pkg.sv
`timescale 1ns / 1ps
package pbsb_pkg;

  // Default geometry of the coordinate format
  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Internal arithmetic word of the offset computation
  localparam int WORD_BITS = 64;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int MUL_STEPS = WORD_BITS;
  localparam int DIV_STEPS = PROD_BITS;
  localparam int CNT_BITS  = 7;

  // Register widths
  localparam int MAC_BITS      = 31;
  localparam int TOL_BITS      = 16;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 32;
  localparam logic [MAC_BITS-1:0] MAC_RESET = MAC_BITS'(6554);
  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(7);

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_ARC_CHORD   = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIRECTION_TOL   = 1'd1;

  // Offset magnitude limit: 2^40
  localparam int OFS_BITS = 41;
  localparam logic [OFS_BITS-1:0] OFFSET_LIMIT = {1'b1, {(OFS_BITS-1){1'b0}}};

  // Command modes
  localparam logic [1:0] MODE_BEGIN  = 2'd0;
  localparam logic [1:0] MODE_VERTEX = 2'd1;
  localparam logic [1:0] MODE_END    = 2'd2;

  // Datapath operations
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_FIRST     = 4'd1;
  localparam logic [3:0] OP_SEG_VTX   = 4'd2;
  localparam logic [3:0] OP_SEG_CLOSE = 4'd3;
  localparam logic [3:0] OP_SETUP     = 4'd4;
  localparam logic [3:0] OP_CHK0      = 4'd5;
  localparam logic [3:0] OP_CHK1      = 4'd6;
  localparam logic [3:0] OP_CHK2      = 4'd7;
  localparam logic [3:0] OP_CHK3      = 4'd8;
  localparam logic [3:0] OP_MUL_LOAD  = 4'd9;
  localparam logic [3:0] OP_MUL_STEP  = 4'd10;
  localparam logic [3:0] OP_PREP      = 4'd11;
  localparam logic [3:0] OP_ROUND     = 4'd12;
  localparam logic [3:0] OP_DIV_STEP  = 4'd13;
  localparam logic [3:0] OP_DIV_DONE  = 4'd14;
  localparam logic [3:0] OP_EMIT      = 4'd15;

  // Operand selection for the shared multiplier and divider
  localparam logic [1:0] SEL_BSQ = 2'd0;
  localparam logic [1:0] SEL_X   = 2'd1;
  localparam logic [1:0] SEL_Y   = 2'd2;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] sel;
    logic       center;
  } cmd_t;

  typedef struct packed {
    logic is_line;
  } status_t;

endpackage

// File: rtl/core/pbsb_ctrl.sv
`timescale 1ns / 1ps
module pbsb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        mode,
  input  logic              closed,
  output logic              out_valid,
  input  logic              out_ready,
  input  pbsb_pkg::status_t status,
  output pbsb_pkg::cmd_t    cmd
);
  import pbsb_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SETUP  = 4'd1;
  localparam logic [3:0] S_CHK0   = 4'd2;
  localparam logic [3:0] S_CHK1   = 4'd3;
  localparam logic [3:0] S_CHK2   = 4'd4;
  localparam logic [3:0] S_CHK3   = 4'd5;
  localparam logic [3:0] S_BRANCH = 4'd6;
  localparam logic [3:0] S_MUL_LD = 4'd7;
  localparam logic [3:0] S_MUL    = 4'd8;
  localparam logic [3:0] S_PREP   = 4'd9;
  localparam logic [3:0] S_ROUND  = 4'd10;
  localparam logic [3:0] S_DIV    = 4'd11;
  localparam logic [3:0] S_DDONE  = 4'd12;
  localparam logic [3:0] S_CENTER = 4'd13;
  localparam logic [3:0] S_FINISH = 4'd14;

  localparam logic [CNT_BITS-1:0] MUL_LAST = CNT_BITS'(MUL_STEPS - 1);
  localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(DIV_STEPS - 1);

  logic [3:0]          state, state_next;
  logic [1:0]          phase, phase_next;
  logic [CNT_BITS-1:0] cnt, cnt_next;
  logic                in_polyline, in_polyline_next;
  logic                awaiting_first, awaiting_first_next;
  logic                is_closed, is_closed_next;
  logic                accept, emit;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign emit     = (state == S_FINISH) && (!out_valid || out_ready);

  // Sequence one item through the datapath
  always_comb begin
    state_next          = state;
    phase_next          = phase;
    cnt_next            = cnt;
    in_polyline_next    = in_polyline;
    awaiting_first_next = awaiting_first;
    is_closed_next      = is_closed;
    cmd.op              = OP_NONE;
    cmd.sel             = phase;
    cmd.center          = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_BEGIN: begin
              in_polyline_next    = 1'b1;
              awaiting_first_next = 1'b1;
              is_closed_next      = closed;
            end
            MODE_VERTEX: begin
              if (awaiting_first) begin
                cmd.op              = OP_FIRST;
                awaiting_first_next = 1'b0;
              end else begin
                cmd.op     = OP_SEG_VTX;
                state_next = S_SETUP;
              end
            end
            MODE_END: begin
              if (in_polyline && is_closed && !awaiting_first) begin
                cmd.op     = OP_SEG_CLOSE;
                state_next = S_SETUP;
              end
              in_polyline_next = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_SETUP: begin
        cmd.op     = OP_SETUP;
        state_next = S_CHK0;
      end
      S_CHK0: begin
        cmd.op     = OP_CHK0;
        state_next = S_CHK1;
      end
      S_CHK1: begin
        cmd.op     = OP_CHK1;
        state_next = S_CHK2;
      end
      S_CHK2: begin
        cmd.op     = OP_CHK2;
        state_next = S_CHK3;
      end
      S_CHK3: begin
        cmd.op     = OP_CHK3;
        state_next = S_BRANCH;
      end
      S_BRANCH: begin
        phase_next = SEL_BSQ;
        state_next = status.is_line ? S_FINISH : S_MUL_LD;
      end
      S_MUL_LD: begin
        cmd.op     = OP_MUL_LOAD;
        cnt_next   = '0;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.op   = OP_MUL_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == MUL_LAST) begin
          state_next = (phase == SEL_BSQ) ? S_PREP : S_ROUND;
        end
      end
      S_PREP: begin
        cmd.op     = OP_PREP;
        phase_next = SEL_X;
        state_next = S_MUL_LD;
      end
      S_ROUND: begin
        cmd.op     = OP_ROUND;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op   = OP_DIV_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          state_next = S_DDONE;
        end
      end
      S_DDONE: begin
        cmd.op = OP_DIV_DONE;
        if (phase == SEL_X) begin
          phase_next = SEL_Y;
          state_next = S_MUL_LD;
        end else begin
          state_next = S_CENTER;
        end
      end
      S_CENTER: begin
        cmd.center = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (emit) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      phase          <= SEL_BSQ;
      cnt            <= '0;
      in_polyline    <= 1'b0;
      awaiting_first <= 1'b1;
      is_closed      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      phase          <= phase_next;
      cnt            <= cnt_next;
      in_polyline    <= in_polyline_next;
      awaiting_first <= awaiting_first_next;
      is_closed      <= is_closed_next;
      // Hold the result beat until taken
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/pbsb_datapath.sv
`timescale 1ns / 1ps
module pbsb_datapath #(
  parameter int COORD_BITS = pbsb_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = pbsb_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pbsb_pkg::cmd_t                      cmd,
  output pbsb_pkg::status_t                   status,
  input  logic                                cfg_wr,
  input  logic [pbsb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [pbsb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic signed [COORD_BITS-1:0]        vertex_x,
  input  logic signed [COORD_BITS-1:0]        vertex_y,
  input  logic signed [COORD_BITS-1:0]        bulge,
  output logic                                segment_kind,
  output logic signed [COORD_BITS-1:0]        start_x,
  output logic signed [COORD_BITS-1:0]        start_y,
  output logic signed [COORD_BITS-1:0]        end_x,
  output logic signed [COORD_BITS-1:0]        end_y,
  output logic signed [COORD_BITS-1:0]        center_x,
  output logic signed [COORD_BITS-1:0]        center_y,
  output logic                                clockwise
);
  import pbsb_pkg::*;

  localparam int DW  = COORD_BITS + 1;
  localparam int SW  = ((DW > OFS_BITS + 1) ? DW : OFS_BITS + 1) + 1;
  localparam int TW  = ((DW > TOL_BITS + 1) ? DW : TOL_BITS + 1) + 1;
  localparam logic [WORD_BITS:0]   ONE2_W = (WORD_BITS + 1)'(1) << (2 * FRAC_BITS);
  localparam logic [WORD_BITS-1:0] ONE2   = ONE2_W[WORD_BITS-1:0];

  // Configuration registers
  logic [MAC_BITS-1:0] min_arc_chord;
  logic [TOL_BITS-1:0] direction_tolerance;

  // Polyline memory
  logic signed [COORD_BITS-1:0] first_x, first_y, prev_x, prev_y, prev_b;

  // Segment under work
  logic signed [COORD_BITS-1:0] sx, sy, ex, ey, sb;
  logic signed [DW-1:0]         dx, dy, mx, my;
  logic [WORD_BITS-1:0]         adx, ady, ab;
  logic                         chord_in_range;

  // Chord check
  logic [2*MAC_BITS-1:0] p;
  logic [2*MAC_BITS:0]   acc;
  logic [MAC_BITS-1:0]   ma, mb;
  logic                  is_line;

  // Shared serial multiplier and divider
  logic [WORD_BITS-1:0] mcand, e, den, rem;
  logic [PROD_BITS-1:0] prod, n;
  logic [WORD_BITS:0]   mul_sum;
  logic [WORD_BITS-1:0] rem_w, bsq;
  logic                 ge;
  logic [OFS_BITS-1:0]  ox, oy, osat;

  // Centre
  logic signed [COORD_BITS-1:0] cx, cy;
  logic signed [SW-1:0]         vx, vy, cx_w, cy_w;
  logic signed [TW-1:0]         dx_t, tol_t;
  logic                         left;

  logic signed [DW-1:0] dx_c, dy_c, sumx, sumy;
  logic [DW-1:0]        adx_c, ady_c;
  logic [COORD_BITS-1:0] ab_c;

  assign status.is_line = is_line;

  // Segment geometry from the loaded end points
  always_comb begin
    dx_c  = DW'(ex) - DW'(sx);
    dy_c  = DW'(ey) - DW'(sy);
    adx_c = dx_c[DW-1] ? DW'(-dx_c) : DW'(dx_c);
    ady_c = dy_c[DW-1] ? DW'(-dy_c) : DW'(dy_c);
    ab_c  = sb[COORD_BITS-1] ? COORD_BITS'(-sb) : COORD_BITS'(sb);
    sumx  = DW'(sx) + DW'(ex);
    sumy  = DW'(sy) + DW'(ey);
  end

  // Pick chord check multiplier operands
  always_comb begin
    case (cmd.op)
      OP_CHK0: begin
        ma = adx[MAC_BITS-1:0];
        mb = adx[MAC_BITS-1:0];
      end
      OP_CHK1: begin
        ma = ady[MAC_BITS-1:0];
        mb = ady[MAC_BITS-1:0];
      end
      default: begin
        ma = min_arc_chord;
        mb = min_arc_chord;
      end
    endcase
  end

  // One multiply step, one divide step and the saturated offset
  always_comb begin
    mul_sum = {1'b0, prod[PROD_BITS-1:WORD_BITS]} + (prod[0] ? {1'b0, mcand} : '0);
    rem_w   = {rem[WORD_BITS-2:0], n[PROD_BITS-1]};
    ge      = (rem_w >= den);
    bsq     = prod[WORD_BITS-1:0];
    if (n[PROD_BITS-1:WORD_BITS] != '0 || n[WORD_BITS-1:0] > WORD_BITS'(OFFSET_LIMIT)) begin
      osat = OFFSET_LIMIT;
    end else begin
      osat = n[OFS_BITS-1:0];
    end
  end

  // Centre on the bisector, side picked by chord direction and bulge sign
  always_comb begin
    vx    = dx[DW-1] ? -SW'(ox) : SW'(ox);
    vy    = dy[DW-1] ? -SW'(oy) : SW'(oy);
    dx_t  = TW'(dx);
    tol_t = TW'({1'b0, direction_tolerance});
    left  = (dx_t > tol_t) || (dx_t < -tol_t);
    if (sb[COORD_BITS-1]) begin
      left = !left;
    end
    if (left) begin
      cx_w = SW'(mx) - vy;
      cy_w = SW'(my) + vx;
    end else begin
      cx_w = SW'(mx) + vy;
      cy_w = SW'(my) - vx;
    end
  end

  function automatic logic signed [COORD_BITS-1:0] sat_c(input logic signed [SW-1:0] v);
    logic [SW-COORD_BITS:0] top;
    top = v[SW-1:COORD_BITS-1];
    if (top == '0 || top == '1) begin
      sat_c = v[COORD_BITS-1:0];
    end else if (v[SW-1]) begin
      sat_c = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      sat_c = {1'b0, {(COORD_BITS-1){1'b1}}};
    end
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_arc_chord       <= MAC_RESET;
      direction_tolerance <= TOL_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_MIN_ARC_CHORD: min_arc_chord       <= cfg_data[MAC_BITS-1:0];
        REG_DIRECTION_TOL: direction_tolerance <= cfg_data[TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Vertex memory, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      first_x <= '0;
      first_y <= '0;
      prev_x  <= '0;
      prev_y  <= '0;
      prev_b  <= '0;
    end else begin
      case (cmd.op)
        OP_FIRST: begin
          first_x <= vertex_x;
          first_y <= vertex_y;
          prev_x  <= vertex_x;
          prev_y  <= vertex_y;
          prev_b  <= bulge;
        end
        OP_SEG_VTX: begin
          prev_x <= vertex_x;
          prev_y <= vertex_y;
          prev_b <= bulge;
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.center) begin
      cx <= sat_c(cx_w);
      cy <= sat_c(cy_w);
    end
    case (cmd.op)
      OP_SEG_VTX: begin
        sx <= prev_x;
        sy <= prev_y;
        ex <= vertex_x;
        ey <= vertex_y;
        sb <= prev_b;
      end
      OP_SEG_CLOSE: begin
        sx <= prev_x;
        sy <= prev_y;
        ex <= first_x;
        ey <= first_y;
        sb <= prev_b;
      end
      OP_SETUP: begin
        dx    <= dx_c;
        dy    <= dy_c;
        adx   <= WORD_BITS'(adx_c);
        ady   <= WORD_BITS'(ady_c);
        ab    <= WORD_BITS'(ab_c);
        mx    <= sumx >>> 1;
        my    <= sumy >>> 1;
        chord_in_range <= (adx_c < DW'(64'h8000_0000)) && (ady_c < DW'(64'h8000_0000));
      end
      OP_CHK0: p <= ma * mb;
      OP_CHK1: begin
        acc <= {1'b0, p};
        p   <= ma * mb;
      end
      OP_CHK2: begin
        acc <= acc + {1'b0, p};
        p   <= ma * mb;
      end
      OP_CHK3: is_line <= (sb == '0) || (chord_in_range && (acc < {1'b0, p}));
      OP_MUL_LOAD: begin
        case (cmd.sel)
          SEL_X: begin
            mcand <= adx;
            prod  <= {{WORD_BITS{1'b0}}, e};
          end
          SEL_Y: begin
            mcand <= ady;
            prod  <= {{WORD_BITS{1'b0}}, e};
          end
          default: begin
            mcand <= ab;
            prod  <= {{WORD_BITS{1'b0}}, ab};
          end
        endcase
      end
      OP_MUL_STEP: prod <= {mul_sum, prod[WORD_BITS-1:1]};
      OP_PREP: begin
        e   <= (bsq >= ONE2) ? bsq - ONE2 : ONE2 - bsq;
        den <= ab << (FRAC_BITS + 2);
      end
      OP_ROUND: begin
        n   <= prod + {{WORD_BITS{1'b0}}, den >> 1};
        rem <= '0;
      end
      OP_DIV_STEP: begin
        rem <= ge ? rem_w - den : rem_w;
        n   <= {n[PROD_BITS-2:0], ge};
      end
      OP_DIV_DONE: begin
        if (cmd.sel == SEL_X) begin
          ox <= osat;
        end else begin
          oy <= osat;
        end
      end
      OP_EMIT: begin
        start_x      <= sx;
        start_y      <= sy;
        end_x        <= ex;
        end_y        <= ey;
        segment_kind <= !is_line;
        center_x     <= is_line ? '0 : cx;
        center_y     <= is_line ? '0 : cy;
        clockwise    <= !is_line && sb[COORD_BITS-1];
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/polyline_bulge_segment_builder_top.sv
`timescale 1ns / 1ps
// Polyline bulge segment builder. Each beat on the slave stream is a polyline
// command (tuser = mode: begin, vertex or end); each vertex after the first, and
// the end of a closed polyline, gives one beat on the master stream describing a
// line or a circular arc in signed Q16.16 coordinates. One command is worked on
// at a time. Begin, the first vertex and ignored commands give no result; a
// straight segment passes the setup and chord check states before its result; an
// arc also uses the shared bit-serial 64x64 multiplier (for the bulge square and
// for each axis) and the restoring 128/64 divider (once per axis). A new command
// is taken while the previous result still waits in the output register.
// Configuration writes are taken every cycle.
module polyline_bulge_segment_builder_top #(
  parameter int COORD_BITS = pbsb_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = pbsb_pkg::FRAC_BITS_DEF,
  parameter int IN_BITS    = ((3 * COORD_BITS + 1 + 7) / 8) * 8,
  parameter int OUT_BITS   = ((6 * COORD_BITS + 1 + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // vertex_x, vertex_y, bulge, closed
  input  logic [IN_BITS-1:0]                 s_axis_tdata,
  // mode
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // start_x, start_y, end_x, end_y, center_x, center_y, clockwise
  output logic [OUT_BITS-1:0]                m_axis_tdata,
  // segment_kind
  output logic [0:0]                         m_axis_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pbsb_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [pbsb_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import pbsb_pkg::*;

  localparam int C = COORD_BITS;

  cmd_t    cmd;
  status_t status;

  logic signed [C-1:0] sx, sy, ex, ey, cx, cy;
  logic                kind, cw;

  assign cfg_ready = 1'b1;

  pbsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .mode      (s_axis_tuser),
    .closed    (s_axis_tdata[3*C]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  pbsb_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_wr       (cfg_valid & cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .vertex_x     (s_axis_tdata[C-1:0]),
    .vertex_y     (s_axis_tdata[2*C-1:C]),
    .bulge        (s_axis_tdata[3*C-1:2*C]),
    .segment_kind (kind),
    .start_x      (sx),
    .start_y      (sy),
    .end_x        (ex),
    .end_y        (ey),
    .center_x     (cx),
    .center_y     (cy),
    .clockwise    (cw)
  );

  // Pack the result beat
  assign m_axis_tuser = kind;
  assign m_axis_tdata = OUT_BITS'({cw, cy, cx, ey, ex, sy, sx});

endmodule
